### rtl/core/q5dq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package q5dq_pkg;

  localparam int unsigned PairsPerBlock = 16;
  localparam int unsigned PairIdxW = 4;
  localparam logic [31:0] F32QnanDefault = 32'h7FC0_0000;
  localparam logic [31:0] F32QuietBit = 32'h0040_0000;
  localparam logic [4:0] CodeOffset = 5'd16;

  // binary16 scale times (code - 16), exact binary32 result
  function automatic logic [31:0] scale_code(input logic [15:0] h, input logic [4:0] code);
    logic        hs;
    logic [4:0]  he;
    logic [9:0]  hm;
    logic        neg;
    logic [4:0]  mag;
    logic        sgn;
    logic [10:0] sig;
    logic [15:0] prod;
    logic [3:0]  p;
    logic [7:0]  be;
    logic [22:0] frac;
    logic [31:0] res;
    hs = h[15];
    he = h[14:10];
    hm = h[9:0];
    neg = ~code[4];
    mag = code[4] ? (code - CodeOffset) : (CodeOffset - code);
    sgn = hs ^ neg;
    sig = (he == 5'd0) ? {1'b0, hm} : {1'b1, hm};
    prod = 16'(sig * mag);
    p = 4'd0;
    for (int i = 1; i < 15; i++) begin
      if (prod[i]) p = 4'(i);
    end
    // exponent: p + max(he,1) - 25 + 127
    be = 8'(p) + 8'((he == 5'd0) ? 5'd1 : he) + 8'd102;
    frac = 23'({7'd0, prod} << (5'd23 - 5'(p)));
    if (he == 5'h1F) begin
      if (hm != 10'd0) res = {hs, 8'hFF, hm, 13'd0} | F32QuietBit;
      else if (mag == 5'd0) res = F32QnanDefault;
      else res = {sgn, 8'hFF, 23'd0};
    end else if ((he == 5'd0 && hm == 10'd0) || mag == 5'd0) begin
      res = {sgn, 31'd0};
    end else begin
      res = {sgn, be, frac};
    end
    return res;
  endfunction

endpackage
`default_nettype wire

### rtl/core/q5_block_dequantizer.sv
`timescale 1ns / 1ps
// q5_block_dequantizer
// Input channel (in_valid/in_ready): one packed Q5_0 block per item, with a
// binary16 scale, 32 high bits, 16 nibble bytes and a final-block flag.
// Output channel (out_valid/out_ready): 16 items per block, pair_index 0..15,
// each carrying element j and element j+16 as binary32 words.
// The block is first captured into the held-block registers, then each pair is
// registered onto the outputs. One pair per cycle while the receiver is ready; the
// block register takes the next block while the sixteenth pair is registered, so
// blocks stream with no gap. The pair counter over the held block paces the pairs.
// A stalled receiver holds the current pair and the counter; no pair is
// dropped or repeated. Reset clears the valid flag and the counter.
`default_nettype none
module q5_block_dequantizer (
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire  [15:0] scale_bits,
  input  wire  [31:0] high_bits,
  input  wire  [63:0] nibbles_first,
  input  wire  [63:0] nibbles_second,
  input  wire         final_block,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [31:0] value_low,
  output logic [31:0] value_high,
  output logic [q5dq_pkg::PairIdxW-1:0] pair_index,
  output logic        last_of_block,
  output logic        end_of_row
);
  import q5dq_pkg::*;

  logic [15:0]          held_scale;
  logic [31:0]          held_high_bits;
  logic [127:0]         held_nibbles;
  logic                 held_final;
  logic                 busy;
  logic [PairIdxW-1:0]  pair_counter;
  logic                 adv;
  logic                 last_pair;
  logic [7:0]           byte_sel;
  logic [4:0]           code_lo;
  logic [4:0]           code_hi;

  assign last_pair = (pair_counter == PairIdxW'(PairsPerBlock - 1));
  assign adv = busy && (!out_valid || out_ready);
  assign in_ready = !busy || (adv && last_pair);

  assign byte_sel = held_nibbles[{pair_counter, 3'd0} +: 8];
  assign code_lo = {held_high_bits[pair_counter], byte_sel[3:0]};
  assign code_hi = {held_high_bits[{1'b1, pair_counter}], byte_sel[7:4]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pair_counter <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (adv) begin
        out_valid <= 1'b1;
        pair_counter <= pair_counter + 1'b1;
        if (last_pair) busy <= 1'b0;
      end
      if (in_valid && in_ready) begin
        busy <= 1'b1;
        pair_counter <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_scale <= scale_bits;
      held_high_bits <= high_bits;
      held_nibbles <= {nibbles_second, nibbles_first};
      held_final <= final_block;
    end
    if (adv) begin
      value_low <= scale_code(held_scale, code_lo);
      value_high <= scale_code(held_scale, code_hi);
      pair_index <= pair_counter;
      last_of_block <= last_pair;
      end_of_row <= last_pair && held_final;
    end
  end

`ifndef SYNTHESIS
  a_end_needs_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && end_of_row |-> last_of_block) else $error("end_of_row without last");
  a_last_idx: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_of_block |-> pair_index == PairIdxW'(PairsPerBlock - 1))
    else $error("last_of_block at wrong index");
  a_no_take_midblock: assert property (@(posedge clk) disable iff (rst)
    busy && !last_pair |-> !in_ready) else $error("input taken mid-block");
`endif

endmodule
`default_nettype wire

### dv/q5_block_dequantizer_tb.sv
`timescale 1ns / 1ps
module q5_block_dequantizer_tb;
  import q5dq_pkg::*;

  typedef struct packed {
    logic [31:0] lo;
    logic [31:0] hi;
    logic [3:0]  idx;
    logic        last;
    logic        eor;
  } pair_t;

  localparam int unsigned IdleLimit = 4000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [15:0] scale_bits = '0;
  logic [31:0] high_bits = '0;
  logic [63:0] nibbles_first = '0;
  logic [63:0] nibbles_second = '0;
  logic        final_block = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] value_low;
  logic [31:0] value_high;
  logic [3:0]  pair_index;
  logic        last_of_block;
  logic        end_of_row;

  pair_t pending_pairs[$];
  int    mismatches = 0;
  int    idle_cycles = 0;
  int    burst_left = 0;
  int    stall_mode = 0;
  logic  sender_done = 1'b0;

  always #4 clk = ~clk;

  q5_block_dequantizer DUT (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .scale_bits(scale_bits), .high_bits(high_bits),
    .nibbles_first(nibbles_first), .nibbles_second(nibbles_second),
    .final_block(final_block), .out_valid(out_valid), .out_ready(out_ready),
    .value_low(value_low), .value_high(value_high), .pair_index(pair_index),
    .last_of_block(last_of_block), .end_of_row(end_of_row)
  );

  function automatic logic [31:0] widen_mul(input logic [15:0] h, input int k);
    logic        s;
    logic [4:0]  e;
    logic [9:0]  m;
    int          mag;
    int          sig;
    int          prod;
    int          p;
    int          ex;
    logic [31:0] frac;
    s = h[15] ^ (k < 0);
    e = h[14:10];
    m = h[9:0];
    mag = (k < 0) ? -k : k;
    if (e == 5'h1F) begin
      if (m != 0) return {h[15], 8'hFF, m, 13'd0} | F32QuietBit;
      if (mag == 0) return F32QnanDefault;
      return {s, 8'hFF, 23'd0};
    end
    if ((e == 0 && m == 0) || mag == 0) return {s, 31'd0};
    sig = (e == 0) ? m : (m | 1024);
    ex = (e == 0) ? -24 : (e - 25);
    prod = sig * mag;
    p = 0;
    while (p < 15 && (prod >> (p + 1)) != 0) p++;
    frac = (prod << (23 - p)) & 32'h7FFFFF;
    return {s, 8'(p + ex + 127), frac[22:0]};
  endfunction

  task automatic predict_block(input logic [15:0] sc, input logic [31:0] hb,
                               input logic [127:0] nib, input logic fin);
    pair_t  pr;
    logic [7:0] b;
    for (int j = 0; j < 16; j++) begin
      b = nib[j*8 +: 8];
      pr.lo = widen_mul(sc, int'({hb[j], b[3:0]}) - 16);
      pr.hi = widen_mul(sc, int'({hb[j+16], b[7:4]}) - 16);
      pr.idx = 4'(j);
      pr.last = (j == 15);
      pr.eor = (j == 15) && fin;
      pending_pairs.push_back(pr);
    end
  endtask

  task automatic send_block(input logic [15:0] sc, input logic [31:0] hb,
                            input logic [127:0] nib, input logic fin);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    scale_bits <= sc;
    high_bits <= hb;
    nibbles_first <= nib[63:0];
    nibbles_second <= nib[127:64];
    final_block <= fin;
    predict_block(sc, hb, nib, fin);
    do @(posedge clk); while (!in_ready);
  endtask

  function automatic logic [127:0] rand_nib();
    return {$urandom, $urandom, $urandom, $urandom};
  endfunction

  task automatic test_scale_classes();
    logic [15:0] scales[12] = '{16'h0000, 16'h8000, 16'h3C00, 16'hBC00, 16'h0001,
                                16'h83FF, 16'h7BFF, 16'hFBFF, 16'h7C00, 16'hFC00,
                                16'h7C01, 16'hFE55};
    foreach (scales[i]) send_block(scales[i], $urandom, rand_nib(), i[0]);
  endtask

  task automatic test_code_extremes();
    send_block(16'h3C00, 32'h0000_0000, '0, 1'b0);
    send_block(16'h3C00, 32'hFFFF_FFFF, '1, 1'b1);
    send_block(16'h7C00, 32'hFFFF_FFFF, '0, 1'b0);
    send_block(16'hFC00, 32'h0000_FFFF, {16{8'hF0}}, 1'b1);
    send_block(16'h0200, 32'hAAAA_5555, {8{16'h0FF0}}, 1'b0);
    send_block(16'hFFFF, 32'h0, '0, 1'b1);
    send_block(16'h7E00, '1, '1, 1'b0);
  endtask

  task automatic test_random_blocks();
    logic [15:0] sc;
    for (int n = 0; n < 390; n++) begin
      case ($urandom_range(0, 9))
        0: sc = {1'($urandom_range(0, 1)), 5'h1F, 10'($urandom)};
        1: sc = {1'($urandom_range(0, 1)), 5'h00, 10'($urandom)};
        2: sc = 16'h8000 & 16'($urandom);
        default: sc = 16'($urandom);
      endcase
      send_block(sc, $urandom, rand_nib(), $urandom_range(0, 3) == 0);
    end
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (stall_mode == 0 && $urandom_range(0, 60) == 0) stall_mode = $urandom_range(1, 3);
      else if (stall_mode != 0 && $urandom_range(0, 40) == 0) stall_mode = 0;
      case (stall_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= $urandom_range(0, 1);
        2: out_ready <= ($urandom_range(0, 4) == 0);
        default: out_ready <= ($urandom_range(0, 9) != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    pair_t exp_pair;
    if (!rst && out_valid && out_ready) begin
      if (pending_pairs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected item idx=%0d", pair_index);
      end else begin
        exp_pair = pending_pairs.pop_front();
        if (exp_pair != {value_low, value_high, pair_index, last_of_block, end_of_row}) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp lo=%h hi=%h idx=%0d last=%b eor=%b got lo=%h hi=%h idx=%0d last=%b eor=%b",
                     exp_pair.lo, exp_pair.hi, exp_pair.idx, exp_pair.last, exp_pair.eor,
                     value_low, value_high, pair_index, last_of_block, end_of_row);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || rst ||
        (sender_done && pending_pairs.size() == 0)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IdleLimit) begin
      $display("q5_block_dequantizer verification failed");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_scale_classes();
    test_code_extremes();
    test_random_blocks();
    in_valid <= 1'b0;
    sender_done = 1'b1;
    wait (pending_pairs.size() == 0);
    repeat (20) @(posedge clk);
    if (mismatches == 0) $display("q5_block_dequantizer verification clean");
    else $display("q5_block_dequantizer verification failed");
    $finish;
  end

endmodule
